// ----- rtl/core/biq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, widths, register map and step program of the biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 20;
	localparam int STATE_W    = 48;
	localparam int ACC_W      = 53;
	localparam int OPND_W     = 25;
	localparam int PROD_W     = COEF_W + OPND_W;
	localparam int YLO_W      = 24;
	localparam int HI_SHIFT   = 7;
	localparam int LO_SHIFT   = 17;
	localparam int FRAC_W     = 32;
	localparam int CLAMP_W    = FRAC_W + 2;
	localparam int GAIN_SHIFT = 15;
	localparam int SCALED_W   = CLAMP_W + GAIN_SHIFT;
	localparam int STEP_W     = 4;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 3;

	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic signed [COEF_W-1:0] B0_RESET = 20'sd131072;

	localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
	localparam logic [STEP_W-1:0] STEP_Y_SUM  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_Y_SAT  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_Z1_X   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_Z1_HI  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_Z1_LO  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_Z2_X   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_Z2_HI  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_Z2_LO  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_DONE   = 4'd9;

	typedef enum logic [2:0] {
		COEF_B0,
		COEF_B1,
		COEF_B2,
		COEF_A1,
		COEF_A2
	} coef_sel_t;

	typedef enum logic [1:0] {
		OPND_X_IN,
		OPND_X_REG,
		OPND_Y_HI,
		OPND_Y_LO
	} opnd_sel_t;

	typedef enum logic [1:0] {
		BASE_ACC,
		BASE_Z1,
		BASE_Z2,
		BASE_ZERO
	} acc_base_t;

	typedef enum logic [1:0] {
		SHIFT_NONE,
		SHIFT_LEFT,
		SHIFT_RIGHT
	} acc_shift_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN,
		WAIT_OUT
	} wait_t;

	typedef struct packed {
		logic              x_we;
		logic              mul_en;
		coef_sel_t         coef_sel;
		opnd_sel_t         opnd_sel;
		logic              acc_en;
		acc_base_t         acc_base;
		logic              acc_sub;
		acc_shift_t        acc_shift;
		logic              y_we;
		logic              p_we;
		logic              z1_we;
		logic              z2_we;
		logic              out_we;
		wait_t             wait_sel;
		logic              jmp_en;
		logic [STEP_W-1:0] jmp_tgt;
	} ctrl_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	function automatic ctrl_t biq_ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		case (step)
			STEP_ACCEPT: begin
				c.wait_sel = WAIT_IN;
				c.x_we     = 1'b1;
				c.mul_en   = 1'b1;
				c.coef_sel = COEF_B0;
				c.opnd_sel = OPND_X_IN;
			end
			STEP_Y_SUM: begin
				c.acc_en   = 1'b1;
				c.acc_base = BASE_Z1;
			end
			STEP_Y_SAT: begin
				c.y_we     = 1'b1;
				c.mul_en   = 1'b1;
				c.coef_sel = COEF_B1;
				c.opnd_sel = OPND_X_REG;
			end
			STEP_Z1_X: begin
				c.p_we     = 1'b1;
				c.acc_en   = 1'b1;
				c.acc_base = BASE_Z2;
				c.mul_en   = 1'b1;
				c.coef_sel = COEF_A1;
				c.opnd_sel = OPND_Y_HI;
			end
			STEP_Z1_HI: begin
				c.acc_en    = 1'b1;
				c.acc_sub   = 1'b1;
				c.acc_shift = SHIFT_LEFT;
				c.mul_en    = 1'b1;
				c.coef_sel  = COEF_A1;
				c.opnd_sel  = OPND_Y_LO;
			end
			STEP_Z1_LO: begin
				c.acc_en    = 1'b1;
				c.acc_sub   = 1'b1;
				c.acc_shift = SHIFT_RIGHT;
				c.mul_en    = 1'b1;
				c.coef_sel  = COEF_B2;
				c.opnd_sel  = OPND_X_REG;
			end
			STEP_Z2_X: begin
				c.z1_we    = 1'b1;
				c.acc_en   = 1'b1;
				c.acc_base = BASE_ZERO;
				c.mul_en   = 1'b1;
				c.coef_sel = COEF_A2;
				c.opnd_sel = OPND_Y_HI;
			end
			STEP_Z2_HI: begin
				c.acc_en    = 1'b1;
				c.acc_sub   = 1'b1;
				c.acc_shift = SHIFT_LEFT;
				c.mul_en    = 1'b1;
				c.coef_sel  = COEF_A2;
				c.opnd_sel  = OPND_Y_LO;
			end
			STEP_Z2_LO: begin
				c.acc_en    = 1'b1;
				c.acc_sub   = 1'b1;
				c.acc_shift = SHIFT_RIGHT;
			end
			STEP_DONE: begin
				c.z2_we    = 1'b1;
				c.out_we   = 1'b1;
				c.wait_sel = WAIT_OUT;
				c.jmp_en   = 1'b1;
				c.jmp_tgt  = STEP_ACCEPT;
			end
			default: begin
				c.jmp_en  = 1'b1;
				c.jmp_tgt = STEP_ACCEPT;
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-STATE_W:0] top;
		top = v[ACC_W-1:STATE_W-1];
		if ((&top) || !(|top)) begin
			return v[STATE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_W-1){1'b1}}};
		end
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/biq_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_cfg
// Register port holding the five filter coefficients.
// ----------------------------------------------------------------------------
module biq_cfg import biq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output coef_t                  coef
);

	coef_t            coef_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;
	logic [COEF_W-1:0] wval;
	logic [COEF_W-1:0] rval;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign wval   = pwdata[COEF_W-1:0];
	assign coef   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= B0_RESET;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_B0:  coef_q.b0 <= wval;
				REG_B1:  coef_q.b1 <= wval;
				REG_B2:  coef_q.b2 <= wval;
				REG_A1:  coef_q.a1 <= wval;
				REG_A2:  coef_q.a2 <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_B0:  rval = coef_q.b0;
			REG_B1:  rval = coef_q.b1;
			REG_B2:  rval = coef_q.b2;
			REG_A1:  rval = coef_q.a1;
			REG_A2:  rval = coef_q.a2;
			default: rval = '0;
		endcase
	end

	assign prdata = {{(DATA_W-COEF_W){rval[COEF_W-1]}}, rval};

endmodule
`default_nettype wire

// ----- rtl/core/biq_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_seq
// Step counter and control store; issues one control word per cycle, holding the step while stalled.
// ----------------------------------------------------------------------------
module biq_seq import biq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_busy,
	output logic      in_ready,
	output ctrl_t     ctrl
);

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;
	ctrl_t             word;
	logic              stall;

	assign word = biq_ucode(pc_q);

	always_comb begin
		unique case (word.wait_sel)
			WAIT_IN:  stall = ~in_valid;
			WAIT_OUT: stall = out_busy;
			default:  stall = 1'b0;
		endcase
	end

	assign in_ready = (word.wait_sel == WAIT_IN);

	always_comb begin
		priority if (stall) begin
			pc_d = pc_q;
		end else if (word.jmp_en) begin
			pc_d = word.jmp_tgt;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	// side effects only on steps that move on
	always_comb begin
		ctrl = word;
		if (stall) begin
			ctrl.x_we   = 1'b0;
			ctrl.mul_en = 1'b0;
			ctrl.acc_en = 1'b0;
			ctrl.y_we   = 1'b0;
			ctrl.p_we   = 1'b0;
			ctrl.z1_we  = 1'b0;
			ctrl.z2_we  = 1'b0;
			ctrl.out_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_ACCEPT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/biq_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_dp
// Shared multiplier, accumulator, filter state and output scaling.
// ----------------------------------------------------------------------------
module biq_dp import biq_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctrl_t                      ctrl,
	input  wire coef_t                      coef,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output logic signed      [SAMPLE_W-1:0] sample_out
);

	localparam logic signed [STATE_W-1:0] ONE_Q = 48'sh0001_0000_0000;

	logic signed [SAMPLE_W-1:0]  x_q;
	logic signed [COEF_W-1:0]    coef_mux;
	logic signed [OPND_W-1:0]    opnd_mux;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     base;
	logic signed [ACC_W-1:0]     addend;
	logic signed [ACC_W-1:0]     acc_d;
	logic signed [STATE_W-1:0]   y_q;
	logic signed [STATE_W-1:0]   z1_q;
	logic signed [STATE_W-1:0]   z2_q;
	logic signed [CLAMP_W-1:0]   yc;
	logic signed [SCALED_W-1:0]  p_d;
	logic signed [SCALED_W-1:0]  p_q;
	logic [SCALED_W-FRAC_W-1:0]  q_full;

	always_comb begin
		case (ctrl.coef_sel)
			COEF_B0: coef_mux = coef.b0;
			COEF_B1: coef_mux = coef.b1;
			COEF_B2: coef_mux = coef.b2;
			COEF_A1: coef_mux = coef.a1;
			COEF_A2: coef_mux = coef.a2;
			default: coef_mux = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.opnd_sel)
			OPND_X_IN:  opnd_mux = {{(OPND_W-SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};
			OPND_X_REG: opnd_mux = {{(OPND_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
			OPND_Y_HI:  opnd_mux = {y_q[STATE_W-1], y_q[STATE_W-1:YLO_W]};
			OPND_Y_LO:  opnd_mux = {1'b0, y_q[YLO_W-1:0]};
			default:    opnd_mux = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.acc_base)
			BASE_ACC:  base = acc_q;
			BASE_Z1:   base = {{(ACC_W-STATE_W){z1_q[STATE_W-1]}}, z1_q};
			BASE_Z2:   base = {{(ACC_W-STATE_W){z2_q[STATE_W-1]}}, z2_q};
			BASE_ZERO: base = '0;
			default:   base = '0;
		endcase
	end

	always_comb begin
		case (ctrl.acc_shift)
			SHIFT_LEFT:  addend = {{(ACC_W-PROD_W-HI_SHIFT){prod_q[PROD_W-1]}},
				prod_q, {HI_SHIFT{1'b0}}};
			SHIFT_RIGHT: addend = {{(ACC_W-PROD_W+LO_SHIFT){prod_q[PROD_W-1]}},
				prod_q[PROD_W-1:LO_SHIFT]};
			default:     addend = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		endcase
	end

	assign acc_d = ctrl.acc_sub ? (base - addend) : (base + addend);

	// clamp to [-1, +1] and scale by 32767
	always_comb begin
		priority if (y_q > ONE_Q) begin
			yc = ONE_Q[CLAMP_W-1:0];
		end else if (y_q < -ONE_Q) begin
			yc = -ONE_Q[CLAMP_W-1:0];
		end else begin
			yc = y_q[CLAMP_W-1:0];
		end
	end

	assign p_d = {yc, {GAIN_SHIFT{1'b0}}} - {{GAIN_SHIFT{yc[CLAMP_W-1]}}, yc};

	// truncate toward zero
	assign q_full = p_q[SCALED_W-1:FRAC_W]
		+ {{(SCALED_W-FRAC_W-1){1'b0}}, (p_q[SCALED_W-1] & (|p_q[FRAC_W-1:0]))};
	assign sample_out = q_full[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.x_we) begin
			x_q <= sample_in;
		end
		if (ctrl.mul_en) begin
			prod_q <= coef_mux * opnd_mux;
		end
		if (ctrl.acc_en) begin
			acc_q <= acc_d;
		end
		if (ctrl.y_we) begin
			y_q <= sat_state(acc_q);
		end
		if (ctrl.p_we) begin
			p_q <= p_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
		end else begin
			if (ctrl.z1_we) begin
				z1_q <= sat_state(acc_q);
			end
			if (ctrl.z2_we) begin
				z2_q <= sat_state(acc_q);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/biquad_iir_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Second-order IIR section, transposed direct form II, Q2.17 coefficients.
// ----------------------------------------------------------------------------
// output: the word is registered at the last step, which holds while the
//   previous word is stalled; one word per pass of the 10-step program, which
//   runs seven products through one shared 20x25 multiplier
// reset: clears the filter state and step counter, coefficients return to
//   b0 = 1.0 and zero for the rest; no output word is pending
module biquad_iir_filter_unit import biq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,  // sample_in
	input  wire logic                s_tlast,  // block_end
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [SAMPLE_W-1:0] m_tdata,  // sample_out
	output logic                     m_tlast,  // block_end_out
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic      [DATA_W-1:0]   prdata,
	output logic                     pready
);

	coef_t                      coef;
	ctrl_t                      ctrl;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       last_q;
	logic                       m_tvalid_q;
	logic [SAMPLE_W-1:0]        m_tdata_q;
	logic                       m_tlast_q;
	logic                       out_busy;

	assign out_busy = m_tvalid_q & ~m_tready;

	biq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	biq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_busy (out_busy),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	biq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.coef       (coef),
		.sample_in  (s_tdata),
		.sample_out (sample_out)
	);

	always_ff @(posedge clk) begin
		if (ctrl.x_we) begin
			last_q <= s_tlast;
		end
		if (ctrl.out_we) begin
			m_tdata_q <= sample_out;
			m_tlast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_we) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

// ----- rtl/core/biq_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_chk
// Port-level checks on the biquad filter, attached by bind.
// ----------------------------------------------------------------------------
module biq_chk import biq_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [SAMPLE_W-1:0] m_tdata,
	input wire logic                m_tlast
);

	localparam logic [SAMPLE_W-1:0] NEG_FULL = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// one word in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in progress");

	// output never reaches negative full scale
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != NEG_FULL)
		else $error("output outside symmetric range");

	// no result the cycle right after an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("output word appeared too early");

endmodule

bind biquad_iir_filter_unit biq_chk u_biq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
